// ===== src/tcf_pkg.sv =====
// Shared types and constants of the tree centre finder.
// Used by every module of the block; depends on nothing else.
package tcf_pkg;

    localparam int FIELD_W = 8;
    localparam int DEG_W   = 8;

    typedef logic [FIELD_W-1:0]      field_t;
    typedef logic signed [DEG_W-1:0] degree_t;

    localparam degree_t DEG_ZERO = degree_t'(0);
    localparam degree_t DEG_ONE  = degree_t'(1);

    // Progress of a vertex through the leaf queue.
    typedef enum logic [1:0] {
        MARK_NEW    = 2'd0,
        MARK_QUEUED = 2'd1,
        MARK_POPPED = 2'd2
    } mark_t;

    // What a parent-chain walk is looking for.
    typedef enum logic [1:0] {
        WALK_SRC,
        WALK_DST,
        WALK_FINAL
    } walk_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_EDGE_A,
        S_EDGE_B,
        S_EDGE_C,
        S_EDGE_D,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_POP,
        S_POP_V,
        S_POP_CHK,
        S_NB,
        S_NB_MARK,
        S_WALK_RD,
        S_WALK_CHK,
        S_LINK,
        S_DEC_RB,
        S_RD_RA,
        S_DEC_RA,
        S_RD_W,
        S_CHK_W,
        S_DONE
    } state_t;

    // Strobes from the sequencer to the memories.
    typedef struct packed {
        logic adj_clr;
        logic adj_set;
        logic adj_rd;
        logic deg_wr;
        logic par_wr;
        logic mark_wr;
        logic queue_wr;
    } mem_cmd_t;

    // Compares on the degree read from memory.
    typedef struct packed {
        logic is_zero;
        logic is_one;
        logic le_one;
    } deg_flags_t;

endpackage

// ===== src/tcf_alu.sv =====
// Shared degree unit: saturating increment or decrement and the degree compares.
// Depends on tcf_pkg.
module tcf_alu
(
    input  tcf_pkg::degree_t    operand,
    input  logic                dec,
    output tcf_pkg::degree_t    sum,
    output tcf_pkg::deg_flags_t flags
);

    localparam int DW = tcf_pkg::DEG_W;
    localparam logic signed [DW:0] SUM_HI = (DW+1)'((2 ** (DW - 1)) - 1);
    localparam logic signed [DW:0] SUM_LO = (DW+1)'(-(2 ** (DW - 1)));

    logic signed [DW:0] wide;

    always_comb
    begin
        wide = {operand[DW-1], operand} + (dec ? {(DW+1){1'b1}} : (DW+1)'(1));
        if (wide > SUM_HI)
        begin
            sum = SUM_HI[DW-1:0];
        end
        else if (wide < SUM_LO)
        begin
            sum = SUM_LO[DW-1:0];
        end
        else
        begin
            sum = wide[DW-1:0];
        end
    end

    assign flags.is_zero = (operand == tcf_pkg::DEG_ZERO);
    assign flags.is_one  = (operand == tcf_pkg::DEG_ONE);
    assign flags.le_one  = (operand <= tcf_pkg::DEG_ONE);

endmodule

// ===== src/tcf_mem.sv =====
// Single-port stores of the block: adjacency rows, degrees, parent links,
// queue marks and the leaf queue, all with registered read data. Depends on tcf_pkg.
module tcf_mem #(
    parameter int MAX_NODES = 128,
    localparam int IW = $clog2(MAX_NODES)
)
(
    input  logic                 clk,
    input  tcf_pkg::mem_cmd_t    cmd,
    input  logic [IW-1:0]        adj_addr,
    input  logic [IW-1:0]        adj_col,
    output logic [MAX_NODES-1:0] adj_row,
    input  logic [IW-1:0]        deg_addr,
    input  tcf_pkg::degree_t     deg_wdata,
    output tcf_pkg::degree_t     deg_q,
    input  logic [IW-1:0]        par_addr,
    input  logic [IW-1:0]        par_wdata,
    output logic [IW-1:0]        par_q,
    input  logic [IW-1:0]        mark_addr,
    input  tcf_pkg::mark_t       mark_wdata,
    output tcf_pkg::mark_t       mark_q,
    input  logic [IW-1:0]        queue_addr,
    input  logic [IW-1:0]        queue_wdata,
    output logic [IW-1:0]        queue_q
);

    logic [MAX_NODES-1:0] adj_mem   [MAX_NODES];
    tcf_pkg::degree_t     deg_mem   [MAX_NODES];
    logic [IW-1:0]        par_mem   [MAX_NODES];
    tcf_pkg::mark_t       mark_mem  [MAX_NODES];
    logic [IW-1:0]        queue_mem [MAX_NODES];

    // A whole row is cleared at once, or a single bit of it is set.
    always_ff @(posedge clk)
    begin
        if (cmd.adj_clr)
        begin
            adj_mem[adj_addr] <= '0;
        end
        else if (cmd.adj_set)
        begin
            adj_mem[adj_addr][adj_col] <= 1'b1;
        end
        if (cmd.adj_rd)
        begin
            adj_row <= adj_mem[adj_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.deg_wr)
        begin
            deg_mem[deg_addr] <= deg_wdata;
        end
        deg_q <= deg_mem[deg_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.par_wr)
        begin
            par_mem[par_addr] <= par_wdata;
        end
        par_q <= par_mem[par_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mark_wr)
        begin
            mark_mem[mark_addr] <= mark_wdata;
        end
        mark_q <= mark_mem[mark_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.queue_wr)
        begin
            queue_mem[queue_addr] <= queue_wdata;
        end
        queue_q <= queue_mem[queue_addr];
    end

endmodule

// ===== src/tcf_ctrl.sv =====
// Sequencer of the tree centre finder: edge loading, leaf peeling, root walks
// and the clearing pass. Drives tcf_mem and tcf_alu; depends on tcf_pkg.
module tcf_ctrl #(
    parameter int MAX_NODES = 128,
    localparam int IW = $clog2(MAX_NODES),
    localparam int CW = $clog2(MAX_NODES + 1)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tcf_pkg::field_t            node_count,
    input  tcf_pkg::field_t            first_vertex,
    input  tcf_pkg::field_t            second_vertex,
    input  logic                       in_last,
    input  logic                       out_free,
    output logic                       result_load,
    output tcf_pkg::field_t            result_vertex,
    output tcf_pkg::mem_cmd_t          cmd,
    output logic [IW-1:0]              adj_addr,
    output logic [IW-1:0]              adj_col,
    input  logic [MAX_NODES-1:0]       adj_row,
    output logic [IW-1:0]              deg_addr,
    output tcf_pkg::degree_t           deg_wdata,
    output logic                       deg_dec,
    input  tcf_pkg::degree_t           deg_sum,
    input  tcf_pkg::deg_flags_t        deg_flags,
    output logic [IW-1:0]              par_addr,
    output logic [IW-1:0]              par_wdata,
    input  logic [IW-1:0]              par_q,
    output logic [IW-1:0]              mark_addr,
    output tcf_pkg::mark_t             mark_wdata,
    input  tcf_pkg::mark_t             mark_q,
    output logic [IW-1:0]              queue_addr,
    output logic [IW-1:0]              queue_wdata,
    input  logic [IW-1:0]              queue_q
);

    tcf_pkg::state_t state_reg, state_next;
    tcf_pkg::walk_t  walk_reg, walk_next;
    tcf_pkg::mark_t  markw_reg, markw_next;
    logic            open_reg, open_next;
    logic            last_reg, last_next;
    logic [CW-1:0]   nodes_reg, nodes_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   head_reg, head_next;
    logic [CW-1:0]   tail_reg, tail_next;
    logic [IW-1:0]   va_reg, va_next;
    logic [IW-1:0]   vb_reg, vb_next;
    logic [IW-1:0]   v_reg, v_next;
    logic [IW-1:0]   x_reg, x_next;
    logic [IW-1:0]   ra_reg, ra_next;
    logic [IW-1:0]   rb_reg, rb_next;

    logic [31:0]     count_wide;
    logic [31:0]     clamp_wide;
    logic [31:0]     eff_wide;
    logic [31:0]     a_wide;
    logic [31:0]     b_wide;
    logic [CW-1:0]   eff_nodes;
    logic            edge_ok;
    logic [IW-1:0]   idx_lo;
    logic            clear_end;
    logic            scan_end;
    logic            queue_empty;
    logic            enq_w;

    // Input decode: the node count is latched by the first item of a case only.
    always_comb
    begin
        count_wide = 32'(node_count);
        if (count_wide == 32'd0)
        begin
            clamp_wide = 32'd1;
        end
        else if (count_wide > 32'(MAX_NODES))
        begin
            clamp_wide = 32'(MAX_NODES);
        end
        else
        begin
            clamp_wide = count_wide;
        end
        eff_nodes = open_reg ? nodes_reg : CW'(clamp_wide);
        eff_wide  = 32'(eff_nodes);
        a_wide    = 32'(first_vertex);
        b_wide    = 32'(second_vertex);
        edge_ok   = (eff_wide >= 32'd2) && (a_wide != 32'd0) && (a_wide <= eff_wide)
                    && (b_wide != 32'd0) && (b_wide <= eff_wide);
    end

    assign idx_lo      = idx_reg[IW-1:0];
    assign clear_end   = (idx_reg == CW'(MAX_NODES - 1));
    assign scan_end    = (idx_reg == nodes_reg);
    assign queue_empty = (head_reg == tail_reg);
    assign enq_w       = (markw_reg == tcf_pkg::MARK_NEW) && deg_flags.le_one;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcf_pkg::S_CLEAR:
            begin
                if (clear_end)
                begin
                    state_next = tcf_pkg::S_IDLE;
                end
            end
            tcf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (edge_ok)
                    begin
                        state_next = tcf_pkg::S_EDGE_A;
                    end
                    else if (in_last)
                    begin
                        state_next = tcf_pkg::S_SCAN_RD;
                    end
                end
            end
            tcf_pkg::S_EDGE_A:   state_next = tcf_pkg::S_EDGE_B;
            tcf_pkg::S_EDGE_B:   state_next = tcf_pkg::S_EDGE_C;
            tcf_pkg::S_EDGE_C:   state_next = tcf_pkg::S_EDGE_D;
            tcf_pkg::S_EDGE_D:
            begin
                state_next = last_reg ? tcf_pkg::S_SCAN_RD : tcf_pkg::S_IDLE;
            end
            tcf_pkg::S_SCAN_RD:
            begin
                state_next = scan_end ? tcf_pkg::S_POP : tcf_pkg::S_SCAN_CHK;
            end
            tcf_pkg::S_SCAN_CHK: state_next = tcf_pkg::S_SCAN_RD;
            tcf_pkg::S_POP:
            begin
                state_next = queue_empty ? tcf_pkg::S_WALK_RD : tcf_pkg::S_POP_V;
            end
            tcf_pkg::S_POP_V:    state_next = tcf_pkg::S_POP_CHK;
            tcf_pkg::S_POP_CHK:
            begin
                state_next = deg_flags.is_zero ? tcf_pkg::S_WALK_RD : tcf_pkg::S_NB;
            end
            tcf_pkg::S_NB:
            begin
                if (scan_end)
                begin
                    state_next = tcf_pkg::S_POP;
                end
                else if (adj_row[idx_lo])
                begin
                    state_next = tcf_pkg::S_NB_MARK;
                end
            end
            tcf_pkg::S_NB_MARK:
            begin
                state_next = (mark_q == tcf_pkg::MARK_POPPED) ? tcf_pkg::S_NB
                                                               : tcf_pkg::S_WALK_RD;
            end
            tcf_pkg::S_WALK_RD:  state_next = tcf_pkg::S_WALK_CHK;
            tcf_pkg::S_WALK_CHK:
            begin
                if (par_q != x_reg)
                begin
                    state_next = tcf_pkg::S_WALK_RD;
                end
                else
                begin
                    unique case (walk_reg)
                        tcf_pkg::WALK_SRC:   state_next = tcf_pkg::S_WALK_RD;
                        tcf_pkg::WALK_DST:   state_next = tcf_pkg::S_LINK;
                        tcf_pkg::WALK_FINAL: state_next = tcf_pkg::S_DONE;
                        default:             state_next = tcf_pkg::S_CLEAR;
                    endcase
                end
            end
            tcf_pkg::S_LINK:     state_next = tcf_pkg::S_DEC_RB;
            tcf_pkg::S_DEC_RB:   state_next = tcf_pkg::S_RD_RA;
            tcf_pkg::S_RD_RA:    state_next = tcf_pkg::S_DEC_RA;
            tcf_pkg::S_DEC_RA:   state_next = tcf_pkg::S_RD_W;
            tcf_pkg::S_RD_W:     state_next = tcf_pkg::S_CHK_W;
            tcf_pkg::S_CHK_W:    state_next = tcf_pkg::S_NB;
            tcf_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = tcf_pkg::S_CLEAR;
                end
            end
            default:             state_next = tcf_pkg::S_CLEAR;
        endcase
    end

    // Outputs: memory strobes, addresses, write data, input ready and the result load.
    always_comb
    begin
        cmd         = '0;
        in_ready    = 1'b0;
        result_load = 1'b0;
        adj_addr    = v_reg;
        adj_col     = vb_reg;
        deg_addr    = idx_lo;
        deg_wdata   = deg_sum;
        deg_dec     = 1'b0;
        par_addr    = x_reg;
        par_wdata   = rb_reg;
        mark_addr   = idx_lo;
        mark_wdata  = tcf_pkg::MARK_QUEUED;
        queue_addr  = head_reg[IW-1:0];
        queue_wdata = idx_lo;
        unique case (state_reg)
            tcf_pkg::S_CLEAR:
            begin
                cmd.adj_clr = 1'b1;
                cmd.deg_wr  = 1'b1;
                cmd.par_wr  = 1'b1;
                cmd.mark_wr = 1'b1;
                adj_addr    = idx_lo;
                deg_wdata   = tcf_pkg::DEG_ZERO;
                par_addr    = idx_lo;
                par_wdata   = idx_lo;
                mark_wdata  = tcf_pkg::MARK_NEW;
            end
            tcf_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
            end
            tcf_pkg::S_EDGE_A:
            begin
                cmd.adj_set = 1'b1;
                adj_addr    = va_reg;
                adj_col     = vb_reg;
                deg_addr    = va_reg;
            end
            tcf_pkg::S_EDGE_B:
            begin
                cmd.adj_set = 1'b1;
                cmd.deg_wr  = 1'b1;
                adj_addr    = vb_reg;
                adj_col     = va_reg;
                deg_addr    = va_reg;
            end
            tcf_pkg::S_EDGE_C:
            begin
                deg_addr = vb_reg;
            end
            tcf_pkg::S_EDGE_D:
            begin
                cmd.deg_wr = 1'b1;
                deg_addr   = vb_reg;
            end
            tcf_pkg::S_SCAN_RD:
            begin
                deg_addr = idx_lo;
            end
            tcf_pkg::S_SCAN_CHK:
            begin
                if (deg_flags.is_one)
                begin
                    cmd.queue_wr = 1'b1;
                    cmd.mark_wr  = 1'b1;
                    queue_addr   = tail_reg[IW-1:0];
                end
            end
            tcf_pkg::S_POP:
            begin
                queue_addr = head_reg[IW-1:0];
            end
            tcf_pkg::S_POP_V:
            begin
                cmd.adj_rd  = 1'b1;
                cmd.mark_wr = 1'b1;
                adj_addr    = queue_q;
                deg_addr    = queue_q;
                mark_addr   = queue_q;
                mark_wdata  = tcf_pkg::MARK_POPPED;
            end
            tcf_pkg::S_POP_CHK:
            begin
                deg_addr = v_reg;
            end
            tcf_pkg::S_NB:
            begin
                mark_addr = idx_lo;
            end
            tcf_pkg::S_NB_MARK:
            begin
                mark_addr = idx_lo;
            end
            tcf_pkg::S_WALK_RD:
            begin
                par_addr = x_reg;
            end
            tcf_pkg::S_WALK_CHK:
            begin
                par_addr = x_reg;
            end
            tcf_pkg::S_LINK:
            begin
                cmd.par_wr = 1'b1;
                par_addr   = ra_reg;
                par_wdata  = rb_reg;
                deg_addr   = rb_reg;
            end
            tcf_pkg::S_DEC_RB:
            begin
                cmd.deg_wr = 1'b1;
                deg_addr   = rb_reg;
                deg_dec    = 1'b1;
            end
            tcf_pkg::S_RD_RA:
            begin
                deg_addr = ra_reg;
            end
            tcf_pkg::S_DEC_RA:
            begin
                cmd.deg_wr = 1'b1;
                deg_addr   = ra_reg;
                deg_dec    = 1'b1;
            end
            tcf_pkg::S_RD_W:
            begin
                deg_addr = idx_lo;
            end
            tcf_pkg::S_CHK_W:
            begin
                if (enq_w)
                begin
                    cmd.queue_wr = 1'b1;
                    cmd.mark_wr  = 1'b1;
                    queue_addr   = tail_reg[IW-1:0];
                end
            end
            tcf_pkg::S_DONE:
            begin
                result_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign result_vertex = tcf_pkg::FIELD_W'(32'(x_reg) + 32'd1);

    // Working registers.
    always_comb
    begin
        walk_next  = walk_reg;
        markw_next = markw_reg;
        open_next  = open_reg;
        last_next  = last_reg;
        nodes_next = nodes_reg;
        idx_next   = idx_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        va_next    = va_reg;
        vb_next    = vb_reg;
        v_next     = v_reg;
        x_next     = x_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        unique case (state_reg)
            tcf_pkg::S_CLEAR:
            begin
                idx_next = clear_end ? '0 : idx_reg + CW'(1);
                head_next = '0;
                tail_next = '0;
            end
            tcf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    nodes_next = eff_nodes;
                    open_next  = !in_last;
                    last_next  = in_last;
                    va_next    = IW'(a_wide - 32'd1);
                    vb_next    = IW'(b_wide - 32'd1);
                    idx_next   = '0;
                end
            end
            tcf_pkg::S_SCAN_CHK:
            begin
                idx_next = idx_reg + CW'(1);
                if (deg_flags.is_one)
                begin
                    tail_next = tail_reg + CW'(1);
                end
            end
            tcf_pkg::S_POP:
            begin
                if (queue_empty)
                begin
                    x_next    = '0;
                    walk_next = tcf_pkg::WALK_FINAL;
                end
            end
            tcf_pkg::S_POP_V:
            begin
                v_next    = queue_q;
                head_next = head_reg + CW'(1);
            end
            tcf_pkg::S_POP_CHK:
            begin
                idx_next  = '0;
                x_next    = '0;
                walk_next = tcf_pkg::WALK_FINAL;
            end
            tcf_pkg::S_NB:
            begin
                if (!scan_end && !adj_row[idx_lo])
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            tcf_pkg::S_NB_MARK:
            begin
                if (mark_q == tcf_pkg::MARK_POPPED)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    markw_next = mark_q;
                    x_next     = v_reg;
                    walk_next  = tcf_pkg::WALK_SRC;
                end
            end
            tcf_pkg::S_WALK_CHK:
            begin
                if (par_q != x_reg)
                begin
                    x_next = par_q;
                end
                else
                begin
                    unique case (walk_reg)
                        tcf_pkg::WALK_SRC:
                        begin
                            ra_next   = x_reg;
                            x_next    = idx_lo;
                            walk_next = tcf_pkg::WALK_DST;
                        end
                        tcf_pkg::WALK_DST:
                        begin
                            rb_next = x_reg;
                        end
                        tcf_pkg::WALK_FINAL:
                        begin
                            x_next = x_reg;
                        end
                        default:
                        begin
                            walk_next = tcf_pkg::WALK_FINAL;
                        end
                    endcase
                end
            end
            tcf_pkg::S_CHK_W:
            begin
                idx_next = idx_reg + CW'(1);
                if (enq_w)
                begin
                    tail_next = tail_reg + CW'(1);
                end
            end
            tcf_pkg::S_DONE:
            begin
                idx_next = '0;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcf_pkg::S_CLEAR;
            walk_reg  <= tcf_pkg::WALK_FINAL;
            open_reg  <= 1'b0;
            last_reg  <= 1'b0;
            idx_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            open_reg  <= open_next;
            last_reg  <= last_next;
            idx_reg   <= idx_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        markw_reg <= markw_next;
        nodes_reg <= nodes_next;
        va_reg    <= va_next;
        vb_reg    <= vb_next;
        v_reg     <= v_next;
        x_reg     <= x_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
    end

endmodule

// ===== src/tree_center_finder.sv =====
// Tree centre finder: takes the edges of one tree, one transfer each, and after the
// transfer flagged last peels leaves until it reaches the centre, then returns the
// 1-based root that vertex 1 reaches. Everything runs on single-port memories and one
// shared degree adder, so the block takes one item at a time. An edge transfer with
// valid endpoints keeps the input busy after it is taken while both adjacency bits
// are written and two read-modify-writes of a degree run; any other non-final
// transfer leaves the input ready. The final transfer starts the peel: a leaf scan
// that reads the degree of each vertex, then for each popped vertex a pop, a degree
// check, a step per candidate index and a mark read per neighbour. Each link adds two
// parent-chain walks, each reading every vertex on its chain, root included, and the
// link and degree updates. When the peel stops, the walk from vertex 1 runs along its
// chain before the result is offered. After the result is loaded into the output
// register, and likewise after reset, a clearing pass over all MAX_NODES entries runs
// during which no input is accepted.
// Depends on tcf_pkg, tcf_alu, tcf_mem and tcf_ctrl.
module tree_center_finder #(
    parameter int MAX_NODES = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // node_count, first_vertex, second_vertex
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // center_vertex
);

    localparam int IW = $clog2(MAX_NODES);

    tcf_pkg::mem_cmd_t   cmd;
    tcf_pkg::degree_t    deg_wdata;
    tcf_pkg::degree_t    deg_q;
    tcf_pkg::degree_t    deg_sum;
    tcf_pkg::deg_flags_t deg_flags;
    tcf_pkg::mark_t      mark_wdata;
    tcf_pkg::mark_t      mark_q;
    tcf_pkg::field_t     result_vertex;
    logic [IW-1:0]       adj_addr;
    logic [IW-1:0]       adj_col;
    logic [MAX_NODES-1:0] adj_row;
    logic [IW-1:0]       deg_addr;
    logic                deg_dec;
    logic [IW-1:0]       par_addr;
    logic [IW-1:0]       par_wdata;
    logic [IW-1:0]       par_q;
    logic [IW-1:0]       mark_addr;
    logic [IW-1:0]       queue_addr;
    logic [IW-1:0]       queue_wdata;
    logic [IW-1:0]       queue_q;
    logic                result_load;
    logic                out_free;
    logic                out_valid_reg;
    tcf_pkg::field_t     out_data_reg;

    // The output register is free when empty or when its transfer completes now.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            out_data_reg <= result_vertex;
        end
    end

    tcf_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .node_count    (s_axis_tdata[7:0]),
        .first_vertex  (s_axis_tdata[15:8]),
        .second_vertex (s_axis_tdata[23:16]),
        .in_last       (s_axis_tlast),
        .out_free      (out_free),
        .result_load   (result_load),
        .result_vertex (result_vertex),
        .cmd           (cmd),
        .adj_addr      (adj_addr),
        .adj_col       (adj_col),
        .adj_row       (adj_row),
        .deg_addr      (deg_addr),
        .deg_wdata     (deg_wdata),
        .deg_dec       (deg_dec),
        .deg_sum       (deg_sum),
        .deg_flags     (deg_flags),
        .par_addr      (par_addr),
        .par_wdata     (par_wdata),
        .par_q         (par_q),
        .mark_addr     (mark_addr),
        .mark_wdata    (mark_wdata),
        .mark_q        (mark_q),
        .queue_addr    (queue_addr),
        .queue_wdata   (queue_wdata),
        .queue_q       (queue_q)
    );

    tcf_mem #(
        .MAX_NODES (MAX_NODES)
    ) u_mem (
        .clk         (clk),
        .cmd         (cmd),
        .adj_addr    (adj_addr),
        .adj_col     (adj_col),
        .adj_row     (adj_row),
        .deg_addr    (deg_addr),
        .deg_wdata   (deg_wdata),
        .deg_q       (deg_q),
        .par_addr    (par_addr),
        .par_wdata   (par_wdata),
        .par_q       (par_q),
        .mark_addr   (mark_addr),
        .mark_wdata  (mark_wdata),
        .mark_q      (mark_q),
        .queue_addr  (queue_addr),
        .queue_wdata (queue_wdata),
        .queue_q     (queue_q)
    );

    tcf_alu u_alu (
        .operand (deg_q),
        .dec     (deg_dec),
        .sum     (deg_sum),
        .flags   (deg_flags)
    );

endmodule

// ===== src/tcf_checker.sv =====
// Port-level checks of the tree centre finder, attached to the top level by bind.
// Depends only on the ports of tree_center_finder.
module tcf_port_checks #(
    parameter int MAX_NODES = 128
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // A result waiting for the sink must not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A result only appears out of the peel and is followed by the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !s_axis_tready && !$past(s_axis_tready))
        else $error("result appeared while input was open");

    // A transfer that does not close a case never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> !$rose(m_axis_tvalid))
        else $error("result without a final transfer");

    // The centre is a 1-based vertex no larger than MAX_NODES.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (MAX_NODES < 256)
            |-> (m_axis_tdata != 8'd0) && (32'(m_axis_tdata) <= MAX_NODES))
        else $error("centre vertex out of range");

endmodule

bind tree_center_finder tcf_port_checks #(.MAX_NODES(MAX_NODES)) u_tcf_checker (.*);

// ===== dv/tcf_checker.sv =====
`timescale 1ns / 100ps
// Checker for tree_center_finder: watches both stream channels, mirrors the leaf-peeling
// search on every accepted edge transfer and compares each returned centre vertex in order.
// Depends on tcf_pkg for the field, degree and mark types.
module tcf_checker
    import tcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // node_count, first_vertex, second_vertex
    input  logic        s_axis_tlast,   // last
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // center_vertex
    output int          mismatches,
    output int          pending
);

    localparam int NODES = 128;

    // Mirror of the block's tree state.
    logic [NODES-1:0] adj_bits [NODES];
    degree_t          deg_cnt [NODES];
    int unsigned      up_link [NODES];
    mark_t            vmark [NODES];
    int unsigned      leaf_fifo [NODES];
    int unsigned      fifo_rd;
    int unsigned      fifo_wr;
    bit               tree_open;
    int unsigned      tree_nodes;

    field_t           center_q [$];
    int               fail_count = 0;
    field_t           want;

    assign mismatches = fail_count;

    function automatic void clear_tree();
        for (int i = 0; i < NODES; i++)
        begin
            adj_bits[i]  = '0;
            deg_cnt[i]   = DEG_ZERO;
            up_link[i]   = i;
            vmark[i]     = MARK_NEW;
            leaf_fifo[i] = 0;
        end
        fifo_rd = 0;
        fifo_wr = 0;
    endfunction

    // Degrees saturate at both ends of the signed 8-bit range.
    function automatic void bump_degree(int unsigned v, int d);
        int x;
        x = int'(deg_cnt[v]) + d;
        if (x > 127)
            x = 127;
        if (x < -128)
            x = -128;
        deg_cnt[v] = degree_t'(x);
    endfunction

    function automatic int unsigned chain_root(int unsigned v);
        int unsigned r;
        r = v;
        for (int s = 0; s < NODES; s++)
        begin
            if (up_link[r] == r)
                break;
            r = up_link[r];
        end
        return r;
    endfunction

    function automatic void join_roots(int unsigned a, int unsigned b);
        int unsigned ra;
        int unsigned rb;
        ra = chain_root(a);
        rb = chain_root(b);
        up_link[ra] = rb;
        bump_degree(rb, -1);
        bump_degree(ra, -1);
    endfunction

    function automatic void queue_leaf(int unsigned v);
        if (fifo_wr < NODES)
        begin
            leaf_fifo[fifo_wr] = v;
            fifo_wr++;
        end
        vmark[v] = MARK_QUEUED;
    endfunction

    function automatic void peel_leaves();
        int unsigned v;
        for (int unsigned i = 0; i < tree_nodes; i++)
            if (deg_cnt[i] == DEG_ONE)
                queue_leaf(i);
        while (fifo_rd != fifo_wr)
        begin
            v = leaf_fifo[fifo_rd];
            fifo_rd++;
            vmark[v] = MARK_POPPED;
            if (deg_cnt[v] == DEG_ZERO)
                break;
            for (int unsigned w = 0; w < tree_nodes; w++)
            begin
                if (!adj_bits[v][w] || vmark[w] == MARK_POPPED)
                    continue;
                join_roots(v, w);
                if (vmark[w] == MARK_NEW && deg_cnt[w] <= DEG_ONE)
                    queue_leaf(w);
            end
        end
    endfunction

    // One accepted edge transfer; the final one of a tree yields the expected centre.
    function automatic void take_edge(field_t n_raw, field_t a, field_t b, logic is_last);
        int unsigned n;
        int unsigned va;
        int unsigned vb;
        n = n_raw;
        if (n == 0)
            n = 1;
        if (n > NODES)
            n = NODES;
        if (!tree_open)
        begin
            clear_tree();
            tree_nodes = n;
            tree_open  = 1'b1;
        end
        if (tree_nodes >= 2 && a >= 1 && a <= tree_nodes && b >= 1 && b <= tree_nodes)
        begin
            va = a - 1;
            vb = b - 1;
            adj_bits[va][vb] = 1'b1;
            adj_bits[vb][va] = 1'b1;
            bump_degree(va, 1);
            bump_degree(vb, 1);
        end
        if (is_last)
        begin
            peel_leaves();
            center_q.push_back(field_t'(chain_root(0) + 1));
            tree_open = 1'b0;
        end
    endfunction

    function automatic void note_mismatch(string what, field_t exp_v, field_t got_v);
        fail_count++;
        if (fail_count <= 10)
            $display("tcf_checker: %s at %0t: expected %0d, got %0d",
                     what, $time, exp_v, got_v);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_tree();
            tree_open  = 1'b0;
            tree_nodes = 1;
            center_q.delete();
            pending <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                take_edge(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                          s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (center_q.size() == 0)
                    note_mismatch("unexpected centre vertex", '0, m_axis_tdata);
                else
                begin
                    want = center_q.pop_front();
                    if (m_axis_tdata !== want)
                        note_mismatch("wrong centre vertex", want, m_axis_tdata);
                end
            end
            pending <= center_q.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Top of the tree_center_finder testbench: drives trees of edges with random gaps and
// back-pressure, and gives the verdict from the failure and pending counts of tcf_checker.
// Depends on tcf_pkg, tree_center_finder and tcf_checker.
module tb;
    import tcf_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    int mismatches;
    int pending;
    int items_sent = 0;
    int results_seen = 0;
    bit long_hold_done = 1'b0;

    tree_center_finder #(.MAX_NODES(128)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    tcf_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // Result side: random stalls, one long hold-off and a stretch with no stalls.
    initial
    begin
        int idle_pct;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                results_seen++;
            idle_pct = (results_seen >= 60 && results_seen < 110) ? 0 : 37;
            if (!long_hold_done && results_seen == 15)
            begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // Offers one transfer, with a random gap first, and returns at its acceptance edge.
    task automatic send_item(input int count, input int a, input int b, input bit is_last);
        int idle_pct;
        idle_pct = (items_sent >= 700 && items_sent < 1000) ? 0 : 37;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {field_t'(b), field_t'(a), field_t'(count)};
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // A random tree on n vertices with shuffled labels and edge order; extras adds
    // repeated edges and self loops.
    task automatic send_tree(input int n, input int extras, input int shown_count);
        int label [128];
        int ea [$];
        int eb [$];
        int j;
        int t;
        int cnt;
        for (int k = 0; k < n; k++)
            label[k] = k + 1;
        for (int k = n - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = label[k];
            label[k] = label[j];
            label[j] = t;
        end
        for (int k = 1; k < n; k++)
        begin
            j = $urandom_range(0, k - 1);
            ea.push_back(label[k]);
            eb.push_back(label[j]);
        end
        for (int k = 0; k < extras; k++)
        begin
            j = $urandom_range(0, n - 1);
            if (ea.size() == 0 || $urandom_range(0, 1))
            begin
                ea.push_back(label[j]);
                eb.push_back(label[j]);
            end
            else
            begin
                j = $urandom_range(0, ea.size() - 1);
                ea.push_back(ea[j]);
                eb.push_back(eb[j]);
            end
        end
        if (ea.size() == 0)
        begin
            ea.push_back($urandom_range(0, 255));
            eb.push_back($urandom_range(0, 255));
        end
        for (int k = ea.size() - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = ea[k];
            ea[k] = ea[j];
            ea[j] = t;
            t = eb[k];
            eb[k] = eb[j];
            eb[j] = t;
        end
        for (int k = 0; k < ea.size(); k++)
        begin
            cnt = shown_count;
            // Only the first transfer of a tree sets the node count.
            if (k > 0 && $urandom_range(0, 7) == 0)
                cnt = $urandom_range(0, 255);
            if ($urandom_range(0, 1))
                send_item(cnt, ea[k], eb[k], k == ea.size() - 1);
            else
                send_item(cnt, eb[k], ea[k], k == ea.size() - 1);
        end
    endtask

    task automatic send_edges(input int count, input int nitems, input int vmax);
        for (int k = 0; k < nitems; k++)
            send_item(count, $urandom_range(0, vmax), $urandom_range(0, vmax), k == nitems - 1);
    endtask

    initial
    begin
        int cases;
        int pick;
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_item(1, 1, 1, 1'b1);           // single node
        send_item(0, 5, 200, 1'b1);         // zero count behaves as one node
        send_item(2, 2, 1, 1'b1);
        send_item(3, 1, 2, 1'b0);           // a later count is ignored
        send_item(200, 2, 3, 1'b1);
        send_item(4, 0, 1, 1'b0);           // endpoints out of range are dropped
        send_item(4, 1, 5, 1'b0);
        send_item(4, 255, 255, 1'b0);
        send_item(4, 1, 2, 1'b0);
        send_item(4, 2, 3, 1'b0);
        send_item(4, 4, 3, 1'b1);
        send_item(3, 1, 2, 1'b0);           // repeated edge and self loop
        send_item(3, 2, 1, 1'b0);
        send_item(3, 2, 2, 1'b0);
        send_item(3, 3, 2, 1'b1);
        send_item(5, 1, 2, 1'b1);           // too few edges
        send_item(3, 1, 2, 1'b0);           // too many edges: a cycle
        send_item(3, 2, 3, 1'b0);
        send_item(3, 3, 1, 1'b1);
        send_item(255, 128, 1, 1'b0);       // count above the maximum is clamped
        send_item(255, 1, 2, 1'b1);

        cases = 0;
        while (items_sent < 1550)
        begin
            pick = $urandom_range(0, 99);
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if (cases == 10 || cases == 90)
                send_tree(128, 0, (cases == 90) ? 255 : 128);
            else if (cases == 30)
            begin
                // Enough self loops to saturate a degree.
                repeat (70) send_item(3, 1, 1, 1'b0);
                send_item(3, 1, 2, 1'b0);
                send_item(3, 3, 2, 1'b1);
            end
            else if (pick < 66)
                send_tree(n, 0, n);
            else if (pick < 76)
                send_tree(n, $urandom_range(1, 3), n);
            else if (pick < 88)
                send_edges(n, $urandom_range(1, n + 2), n + 1);
            else
                send_edges($urandom_range(0, 255), $urandom_range(1, 4), 255);
            if (cases == 40 || cases == 150)
                drain_results();
            cases++;
        end

        drain_results();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tcf_pkg.sv
src/tcf_alu.sv
src/tcf_mem.sv
src/tcf_ctrl.sv
src/tree_center_finder.sv
src/tcf_checker.sv
dv/tcf_checker.sv
dv/tb.sv
